[src/source_code_tokenizer_assert.svh]
// Assertion macros for the source code tokenizer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SOURCE_CODE_TOKENIZER_ASSERT_SVH
`define SOURCE_CODE_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
// plain property, checked every clock outside reset
`define SCT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sct assertion failed");
// same-cycle implication
`define SCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sct assertion failed");
// next-cycle implication
`define SCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sct assertion failed");
`else
`define SCT_ASSERT(label, clk, rst_n, prop)
`define SCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SCT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/sct_pkg.sv]
// Shared types, constants and helpers for the source code tokenizer.
// No dependencies; imported by every module of the block.
package sct_pkg;

  // token length limit
  localparam int unsigned MAX_TOKEN_LEN = 1024;
  localparam int unsigned TOKEN_LIMIT   = (MAX_TOKEN_LEN > 1) ? MAX_TOKEN_LEN - 1 : 1;
  localparam int unsigned TLEN_W        = (MAX_TOKEN_LEN > 2) ? $clog2(MAX_TOKEN_LEN) : 1;

  // result queue sizing
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned NCNT_W      = 2;
  localparam int unsigned RQ_DEPTH    = 8;
  localparam int unsigned RQ_AW       = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CW       = $clog2(RQ_DEPTH + 1);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_COLONS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_LINEC  = 1'd1;

  // token kinds
  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_BREAK  = 2'd1;
  localparam logic [1:0] KIND_STRING = 2'd2;
  localparam logic [1:0] KIND_WIDE   = 2'd3;

  // characters of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_UPPERL = 8'h4c;
  localparam logic [7:0] CH_LBRK   = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRK   = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  // classification of one text byte
  typedef struct packed {
    logic zero;
    logic ws;
    logic nl;
    logic slash;
    logic star;
    logic quote;
    logic bslash;
    logic wide_l;
    logic brk;
  } byte_class_t;

  // one result beat
  typedef struct packed {
    logic [7:0]  ch;
    logic [1:0]  kind;
    logic        first;
    logic        last;
    logic        empty;
    logic        eot;
    logic [31:0] line;
  } token_t;

  function automatic token_t mk_tok(input logic [7:0] ch, input logic [1:0] kind,
                                    input logic first, input logic last,
                                    input logic empty, input logic eot,
                                    input logic [31:0] line);
    token_t t;
    t.ch    = ch;
    t.kind  = kind;
    t.first = first;
    t.last  = last;
    t.empty = empty;
    t.eot   = eot;
    t.line  = line;
    return t;
  endfunction

endpackage

[src/sct_class.sv]
// Byte classifier: decodes one text byte into the flags the scanner needs.
// Depends on sct_pkg.
module sct_class import sct_pkg::*; (
  input  logic [7:0]  byte_i,
  input  logic        ignore_colons_i,
  output byte_class_t cls_o
);

  logic brk_fixed;

  // fixed break set, slash included
  always_comb begin
    unique case (byte_i)
      CH_LBRACE, CH_RBRACE, CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK,
      CH_APOS, CH_SLASH, CH_COMMA, CH_SEMI, CH_LT, CH_GT: brk_fixed = 1'b1;
      default: brk_fixed = 1'b0;
    endcase
  end

  assign cls_o.zero   = (byte_i == CH_NUL);
  assign cls_o.ws     = (byte_i <= CH_SPACE);
  assign cls_o.nl     = (byte_i == CH_LF);
  assign cls_o.slash  = (byte_i == CH_SLASH);
  assign cls_o.star   = (byte_i == CH_STAR);
  assign cls_o.quote  = (byte_i == CH_QUOTE);
  assign cls_o.bslash = (byte_i == CH_BSLASH);
  assign cls_o.wide_l = (byte_i == CH_UPPERL);
  assign cls_o.brk    = brk_fixed | ((byte_i == CH_COLON) & ~ignore_colons_i);

endmodule

[src/sct_scan.sv]
// Front end: configuration registers, scan state machine and token builder.
// Depends on sct_pkg and sct_class; writes up to two beats per byte.
module sct_scan import sct_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic                  cfg_data_i,
  input  logic                  accept_i,
  input  logic [7:0]            byte_i,
  output logic [NCNT_W-1:0]     wr_cnt_o,
  output token_t                wr_tok_o [MAX_RESULTS]
);

  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_WORD   = 3'd1,
    M_STRING = 3'd2,
    M_SLASH  = 3'd3,
    M_WIDE   = 3'd4,
    M_LINEC  = 3'd5,
    M_BLOCKC = 3'd6
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [7:0]        held;
    logic              hv;
    logic [TLEN_W-1:0] len;
    logic              ab;
    logic              star;
  } scan_t;

  localparam logic [TLEN_W-1:0] LEN_ONE   = TLEN_W'(1);
  localparam logic [TLEN_W-1:0] LEN_LIMIT = TLEN_W'(TOKEN_LIMIT);

  function automatic scan_t idle_state(input logic [7:0] held);
    scan_t s;
    s.mode = M_IDLE;
    s.held = held;
    s.hv   = 1'b0;
    s.len  = '0;
    s.ab   = 1'b0;
    s.star = 1'b0;
    return s;
  endfunction

  scan_t       st_q, st_d;
  logic [31:0] nl_q, nl_d;
  logic        ign_colons_q, ign_colons_d;
  logic        ign_linec_q, ign_linec_d;
  byte_class_t cls;

  sct_class u_class (
    .byte_i          (byte_i),
    .ignore_colons_i (ign_colons_q),
    .cls_o           (cls)
  );

  // configuration writes
  always_comb begin
    ign_colons_d = ign_colons_q;
    ign_linec_d  = ign_linec_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IGNORE_COLONS: ign_colons_d = cfg_data_i;
        CFG_IGNORE_LINEC:  ign_linec_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  // one byte step: pre-step on the current mode, then word and idle handling
  always_comb begin
    token_t            rec [MAX_RESULTS];
    logic [NCNT_W-1:0] n;
    logic              do_word;
    logic              do_idle;
    logic              first;

    st_d    = st_q;
    nl_d    = nl_q;
    n       = '0;
    do_word = 1'b0;
    do_idle = 1'b0;
    first   = 1'b0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      rec[k] = '0;
    end

    if (accept_i) begin
      if (cls.zero) begin
        // end of text: flush pending token, add end marker, clear
        unique case (st_q.mode)
          M_WORD: begin
            rec[n] = mk_tok(st_q.held, KIND_WORD, st_q.len == LEN_ONE, 1'b1, 1'b0, 1'b0, nl_q);
            n = n + 1'b1;
          end
          M_SLASH: begin
            rec[n] = mk_tok(CH_SLASH, KIND_BREAK, 1'b1, 1'b1, 1'b0, 1'b0, nl_q);
            n = n + 1'b1;
          end
          M_WIDE: begin
            rec[n] = mk_tok(CH_UPPERL, KIND_WORD, 1'b1, 1'b1, 1'b0, 1'b0, nl_q);
            n = n + 1'b1;
          end
          M_STRING: begin
            if (st_q.hv) begin
              rec[n] = mk_tok(st_q.held, KIND_STRING, st_q.len == LEN_ONE, 1'b1,
                              1'b0, 1'b0, nl_q);
            end else begin
              rec[n] = mk_tok(CH_NUL, KIND_STRING, 1'b1, 1'b1, 1'b1, 1'b0, nl_q);
            end
            n = n + 1'b1;
          end
          default: ;
        endcase
        rec[n] = mk_tok(CH_NUL, KIND_WORD, 1'b0, 1'b0, 1'b0, 1'b1, nl_q);
        n = n + 1'b1;
        st_d = idle_state(st_q.held);
        nl_d = '0;
      end else begin
        unique case (st_q.mode)
          M_WORD: begin
            do_word = 1'b1;
          end
          M_STRING: begin
            first = (st_q.len == LEN_ONE);
            if (cls.quote && !st_q.ab) begin
              if (st_q.hv) begin
                rec[n] = mk_tok(st_q.held, KIND_STRING, first, 1'b1, 1'b0, 1'b0, nl_q);
              end else begin
                rec[n] = mk_tok(CH_NUL, KIND_STRING, 1'b1, 1'b1, 1'b1, 1'b0, nl_q);
              end
              n = n + 1'b1;
              st_d = idle_state(st_q.held);
            end else begin
              if (st_q.hv) begin
                rec[n] = mk_tok(st_q.held, KIND_STRING, first, 1'b0, 1'b0, 1'b0, nl_q);
                n = n + 1'b1;
              end
              st_d.held = byte_i;
              st_d.hv   = 1'b1;
              st_d.len  = st_q.len + LEN_ONE;
              st_d.ab   = cls.bslash;
              if (st_d.len >= LEN_LIMIT) begin
                rec[n] = mk_tok(byte_i, KIND_STRING, st_d.len == LEN_ONE, 1'b1,
                                1'b0, 1'b0, nl_q);
                n = n + 1'b1;
                st_d = idle_state(byte_i);
              end
            end
          end
          M_SLASH: begin
            if (cls.slash && !ign_linec_q) begin
              st_d      = idle_state(st_q.held);
              st_d.mode = M_LINEC;
            end else if (cls.star) begin
              st_d      = idle_state(st_q.held);
              st_d.mode = M_BLOCKC;
            end else begin
              rec[n] = mk_tok(CH_SLASH, KIND_BREAK, 1'b1, 1'b1, 1'b0, 1'b0, nl_q);
              n = n + 1'b1;
              st_d    = idle_state(st_q.held);
              do_idle = 1'b1;
            end
          end
          M_WIDE: begin
            if (cls.quote) begin
              rec[n] = mk_tok(CH_UPPERL, KIND_WIDE, 1'b1, 1'b1, 1'b0, 1'b0, nl_q);
              n = n + 1'b1;
              st_d      = idle_state(st_q.held);
              st_d.mode = M_STRING;
            end else begin
              // the held L opens a word
              st_d.mode = M_WORD;
              st_d.held = CH_UPPERL;
              st_d.hv   = 1'b1;
              st_d.len  = LEN_ONE;
              if (LEN_ONE >= LEN_LIMIT) begin
                rec[n] = mk_tok(CH_UPPERL, KIND_WORD, 1'b1, 1'b1, 1'b0, 1'b0, nl_q);
                n = n + 1'b1;
                st_d    = idle_state(CH_UPPERL);
                do_idle = 1'b1;
              end else begin
                do_word = 1'b1;
              end
            end
          end
          M_LINEC: begin
            if (cls.nl) begin
              st_d    = idle_state(st_q.held);
              do_idle = 1'b1;
            end
          end
          M_BLOCKC: begin
            if (cls.nl) begin
              nl_d = nl_q + 32'd1;
            end
            if (st_q.star && cls.slash) begin
              st_d = idle_state(st_q.held);
            end else begin
              st_d.star = cls.star;
            end
          end
          default: begin
            st_d    = idle_state(st_q.held);
            do_idle = 1'b1;
          end
        endcase

        // word continuation or close
        if (do_word) begin
          first = (st_d.len == LEN_ONE);
          if (cls.ws || cls.brk) begin
            rec[n] = mk_tok(st_d.held, KIND_WORD, first, 1'b1, 1'b0, 1'b0, nl_q);
            n = n + 1'b1;
            st_d    = idle_state(st_d.held);
            do_idle = 1'b1;
          end else begin
            rec[n] = mk_tok(st_d.held, KIND_WORD, first, 1'b0, 1'b0, 1'b0, nl_q);
            n = n + 1'b1;
            st_d.held = byte_i;
            st_d.len  = st_d.len + LEN_ONE;
            if (st_d.len >= LEN_LIMIT) begin
              rec[n] = mk_tok(byte_i, KIND_WORD, 1'b0, 1'b1, 1'b0, 1'b0, nl_q);
              n = n + 1'b1;
              st_d = idle_state(byte_i);
            end
          end
        end

        // byte seen between tokens
        if (do_idle) begin
          if (cls.ws) begin
            if (cls.nl) begin
              nl_d = nl_d + 32'd1;
            end
          end else if (cls.slash) begin
            st_d.mode = M_SLASH;
            st_d.held = byte_i;
            st_d.hv   = 1'b1;
          end else if (cls.wide_l) begin
            st_d.mode = M_WIDE;
            st_d.held = byte_i;
            st_d.hv   = 1'b1;
          end else if (cls.quote) begin
            st_d.mode = M_STRING;
          end else if (cls.brk) begin
            rec[n] = mk_tok(byte_i, KIND_BREAK, 1'b1, 1'b1, 1'b0, 1'b0, nl_q);
            n = n + 1'b1;
          end else begin
            st_d.mode = M_WORD;
            st_d.held = byte_i;
            st_d.hv   = 1'b1;
            st_d.len  = LEN_ONE;
            if (LEN_ONE >= LEN_LIMIT) begin
              rec[n] = mk_tok(byte_i, KIND_WORD, 1'b1, 1'b1, 1'b0, 1'b0, nl_q);
              n = n + 1'b1;
              st_d = idle_state(byte_i);
            end
          end
        end
      end
    end

    wr_cnt_o = n;
    wr_tok_o = rec;
  end

  // state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= idle_state(8'h00);
      nl_q         <= '0;
      ign_colons_q <= 1'b0;
      ign_linec_q  <= 1'b0;
    end else begin
      st_q         <= st_d;
      nl_q         <= nl_d;
      ign_colons_q <= ign_colons_d;
      ign_linec_q  <= ign_linec_d;
    end
  end

endmodule

[src/sct_resq.sv]
// Back end: result queue taking up to three beats a cycle, one out per pop.
// Depends on sct_pkg and the assertion macro header.
`include "source_code_tokenizer_assert.svh"
module sct_resq import sct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [NCNT_W-1:0] wr_cnt_i,
  input  token_t            wr_tok_i [MAX_RESULTS],
  input  logic              rd_i,
  output token_t            head_o,
  output logic              empty_o,
  output logic              full_o
);

  token_t            mem_q [RQ_DEPTH];
  logic [RQ_AW-1:0]  wp_q, wp_d;
  logic [RQ_AW-1:0]  rp_q, rp_d;
  logic [RQ_CW-1:0]  cnt_q, cnt_d;
  logic              rd_ok;

  assign empty_o = (cnt_q == '0);
  // room must remain for the largest burst of one byte
  assign full_o  = (cnt_q > RQ_CW'(RQ_DEPTH - MAX_RESULTS));
  assign rd_ok   = rd_i & ~empty_o;
  assign head_o  = mem_q[rp_q];

  // pointers and fill level
  always_comb begin
    wp_d  = wp_q + RQ_AW'(wr_cnt_i);
    rp_d  = rp_q + RQ_AW'(rd_ok);
    cnt_d = cnt_q + RQ_CW'(wr_cnt_i) - RQ_CW'(rd_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // beat storage, written in order from the write pointer
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (NCNT_W'(k) < wr_cnt_i) begin
        mem_q[wp_q + RQ_AW'(k)] <= wr_tok_i[k];
      end
    end
  end

  `SCT_ASSERT(a_cnt_bound, clk_i, rst_ni, (cnt_q <= RQ_CW'(RQ_DEPTH)))
  `SCT_ASSERT_IMP(a_no_overfill, clk_i, rst_ni, (wr_cnt_i != '0), (cnt_q <= (RQ_CW'(RQ_DEPTH) - RQ_CW'(wr_cnt_i))))
  `SCT_ASSERT_NXT(a_pop_drains, clk_i, rst_ni, (rd_ok && (wr_cnt_i == '0)), (cnt_q == ($past(cnt_q) - RQ_CW'(1))))

endmodule

[src/source_code_tokenizer.sv]
// Top level of the source code tokenizer: byte queue port in, token queue port out.
// Depends on sct_pkg, sct_scan (with sct_class) and sct_resq.
//
//  port group   direction  handshake           payload
//  text in      in         push / full         text_byte_i
//  tokens out   out        empty / pop         token_char_o .. line_count_o
//  config       in         cfg_valid_i/_ready  cfg_index_i, cfg_data_i
//
// One text byte is taken per cycle while full is low; it yields zero to two
// token beats, written into an eight-entry result queue the same cycle.
// A beat can be popped the cycle after its byte was pushed; one beat leaves per cycle.
// full rises when fewer than three queue entries are free, so a stalled pop side
// holds off the input after a few bytes; config writes are always taken.
// Reset clears scan state, line count and configuration; no clearing pass.
module source_code_tokenizer import sct_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           text_byte_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           token_char_o,
  output logic [1:0]           token_kind_o,
  output logic                 first_of_token_o,
  output logic                 last_of_token_o,
  output logic                 empty_token_o,
  output logic                 end_of_text_o,
  output logic [31:0]          line_count_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i
);

  logic              accept;
  logic [NCNT_W-1:0] wr_cnt;
  token_t            wr_tok [MAX_RESULTS];
  token_t            head;

  assign accept      = push & ~full;
  assign cfg_ready_o = 1'b1;

  sct_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .byte_i      (text_byte_i),
    .wr_cnt_o    (wr_cnt),
    .wr_tok_o    (wr_tok)
  );

  sct_resq u_resq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_cnt_i (wr_cnt),
    .wr_tok_i (wr_tok),
    .rd_i     (pop),
    .head_o   (head),
    .empty_o  (empty),
    .full_o   (full)
  );

  // result fields from the queue head
  assign token_char_o     = head.ch;
  assign token_kind_o     = head.kind;
  assign first_of_token_o = head.first;
  assign last_of_token_o  = head.last;
  assign empty_token_o    = head.empty;
  assign end_of_text_o    = head.eot;
  assign line_count_o     = head.line;

endmodule

[tb/source_code_tokenizer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for source_code_tokenizer: random and directed text streams.
// Depends on sct_pkg and the tokenizer RTL; expected token beats come from a scoreboard class.
module source_code_tokenizer_tb;
  import sct_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_BYTES   = 36;
  localparam logic [7:0] BREAK_CHARS [13] = '{CH_LBRACE, CH_RBRACE, CH_LPAR, CH_RPAR,
                                              CH_LBRK, CH_RBRK, CH_APOS, CH_SLASH,
                                              CH_COMMA, CH_SEMI, CH_LT, CH_GT, CH_COLON};

  typedef enum logic [2:0] {
    LX_IDLE, LX_WORD, LX_STRING, LX_SLASH, LX_WIDE, LX_LINEC, LX_BLOCKC
  } lex_mode_e;

  // Scoreboard: tracks the lexer state per accepted byte and queues the token beats due
  class token_tracker;
    bit          colon_plain;
    bit          slashes_plain;
    lex_mode_e   mode;
    logic [7:0]  held;
    bit          held_ok;
    int unsigned run_len;
    bit          escaped;
    bit          star_prev;
    logic [31:0] line_total;
    token_t      pending[$];
    int unsigned errors;
    int unsigned matched;

    function new();
      colon_plain   = 0;
      slashes_plain = 0;
      line_total    = '0;
      errors        = 0;
      matched       = 0;
      clear_scan();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, bit val);
      case (idx)
        CFG_IGNORE_COLONS: colon_plain = val;
        CFG_IGNORE_LINEC:  slashes_plain = val;
        default: ;
      endcase
    endfunction

    function void clear_scan();
      mode      = LX_IDLE;
      held      = '0;
      held_ok   = 0;
      run_len   = 0;
      escaped   = 0;
      star_prev = 0;
    endfunction

    function bit is_break(logic [7:0] b);
      case (b)
        CH_LBRACE, CH_RBRACE, CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK,
        CH_APOS, CH_SLASH, CH_COMMA, CH_SEMI, CH_LT, CH_GT: return 1;
        CH_COLON: return !colon_plain;
        default:  return 0;
      endcase
    endfunction

    function void add(logic [7:0] ch, logic [1:0] kind, bit first_ch, bit last_ch,
                      bit empty_str, bit eot);
      token_t t;
      t.ch    = ch;
      t.kind  = kind;
      t.first = first_ch;
      t.last  = last_ch;
      t.empty = empty_str;
      t.eot   = eot;
      t.line  = line_total;
      pending.push_back(t);
    endfunction

    function void word_open(logic [7:0] b);
      mode    = LX_WORD;
      held    = b;
      held_ok = 1;
      run_len = 1;
      if (run_len >= TOKEN_LIMIT) begin
        add(b, KIND_WORD, 1, 1, 0, 0);
        clear_scan();
      end
    endfunction

    function void idle_byte(logic [7:0] b);
      if (b <= CH_SPACE) begin
        if (b == CH_LF) line_total++;
      end else if (b == CH_SLASH || b == CH_UPPERL) begin
        // held back until the next byte settles it
        mode    = (b == CH_SLASH) ? LX_SLASH : LX_WIDE;
        held    = b;
        held_ok = 1;
      end else if (b == CH_QUOTE) begin
        clear_scan();
        mode = LX_STRING;
      end else if (is_break(b)) begin
        add(b, KIND_BREAK, 1, 1, 0, 0);
      end else begin
        word_open(b);
      end
    endfunction

    function void word_byte(logic [7:0] b);
      bit first_ch;
      first_ch = (run_len == 1);
      if (b <= CH_SPACE || is_break(b)) begin
        add(held, KIND_WORD, first_ch, 1, 0, 0);
        clear_scan();
        idle_byte(b);
        return;
      end
      add(held, KIND_WORD, first_ch, 0, 0, 0);
      held = b;
      run_len++;
      if (run_len >= TOKEN_LIMIT) begin
        add(b, KIND_WORD, 0, 1, 0, 0);
        clear_scan();
      end
    endfunction

    function void string_byte(logic [7:0] b);
      bit first_ch;
      first_ch = (run_len == 1);
      if (b == CH_QUOTE && !escaped) begin
        if (held_ok) add(held, KIND_STRING, first_ch, 1, 0, 0);
        else add(8'h00, KIND_STRING, 1, 1, 1, 0);
        clear_scan();
        return;
      end
      if (held_ok) add(held, KIND_STRING, first_ch, 0, 0, 0);
      held    = b;
      held_ok = 1;
      run_len++;
      escaped = (b == CH_BSLASH);
      if (run_len >= TOKEN_LIMIT) begin
        add(b, KIND_STRING, run_len == 1, 1, 0, 0);
        clear_scan();
      end
    endfunction

    // byte 0: flush whatever is open, then the end marker, then a clean slate
    function void close_text();
      case (mode)
        LX_WORD:  add(held, KIND_WORD, run_len == 1, 1, 0, 0);
        LX_SLASH: add(CH_SLASH, KIND_BREAK, 1, 1, 0, 0);
        LX_WIDE:  add(CH_UPPERL, KIND_WORD, 1, 1, 0, 0);
        LX_STRING: begin
          if (held_ok) add(held, KIND_STRING, run_len == 1, 1, 0, 0);
          else add(8'h00, KIND_STRING, 1, 1, 1, 0);
        end
        default: ;
      endcase
      add(8'h00, KIND_WORD, 0, 0, 0, 1);
      clear_scan();
      line_total = '0;
    endfunction

    function void take_byte(logic [7:0] b);
      if (b == CH_NUL) begin
        close_text();
        return;
      end
      case (mode)
        LX_WORD:   word_byte(b);
        LX_STRING: string_byte(b);
        LX_SLASH: begin
          if (b == CH_SLASH && !slashes_plain) begin
            clear_scan();
            mode = LX_LINEC;
          end else if (b == CH_STAR) begin
            clear_scan();
            mode = LX_BLOCKC;
          end else begin
            add(CH_SLASH, KIND_BREAK, 1, 1, 0, 0);
            clear_scan();
            idle_byte(b);
          end
        end
        LX_WIDE: begin
          if (b == CH_QUOTE) begin
            add(CH_UPPERL, KIND_WIDE, 1, 1, 0, 0);
            clear_scan();
            mode = LX_STRING;
          end else begin
            word_open(CH_UPPERL);
            if (mode == LX_WORD) word_byte(b);
            else idle_byte(b);
          end
        end
        LX_LINEC: begin
          if (b == CH_LF) begin
            clear_scan();
            idle_byte(b);
          end
        end
        LX_BLOCKC: begin
          if (b == CH_LF) line_total++;
          if (star_prev && b == CH_SLASH) clear_scan();
          else star_prev = (b == CH_STAR);
        end
        default: begin
          clear_scan();
          idle_byte(b);
        end
      endcase
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: beat %0d %s mismatch, expected %0h, actual %0h",
                 $time, matched, field, want, got);
      end
    endfunction

    function void match_token(token_t got);
      token_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual char %0h kind %0d eot %0b",
                 $time, got.ch, got.kind, got.eot);
        return;
      end
      want = pending.pop_front();
      check_field("token_char", want.ch, got.ch);
      check_field("token_kind", want.kind, got.kind);
      check_field("first_of_token", want.first, got.first);
      check_field("last_of_token", want.last, got.last);
      check_field("empty_token", want.empty, got.empty);
      check_field("end_of_text", want.eot, got.eot);
      check_field("line_count", want.line, got.line);
      matched++;
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           text_byte = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [7:0]           token_char;
  logic [1:0]           token_kind;
  logic                 first_of_token;
  logic                 last_of_token;
  logic                 empty_token;
  logic                 end_of_text;
  logic [31:0]          line_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IGNORE_COLONS;
  logic                 cfg_data = 1'b0;

  token_tracker tracker = new();
  logic [7:0]   text_buf[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  hold_reqs = 0;
  int unsigned  holds_done = 0;
  int unsigned  stall_left = 0;
  int unsigned  cycles = 0;
  int unsigned  bytes_sent = 0;

  source_code_tokenizer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .text_byte_i      (text_byte),
    .empty            (empty),
    .pop              (pop),
    .token_char_o     (token_char),
    .token_kind_o     (token_kind),
    .first_of_token_o (first_of_token),
    .last_of_token_o  (last_of_token),
    .empty_token_o    (empty_token),
    .end_of_text_o    (end_of_text),
    .line_count_o     (line_count),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // run guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats outstanding", $time, tracker.pending.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // pop side: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_reqs != holds_done) begin
      holds_done = hold_reqs;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // every popped beat goes to the scoreboard
  always @(posedge clk_i) begin
    token_t seen;
    if (rst_ni && pop && !empty) begin
      seen.ch    = token_char;
      seen.kind  = token_kind;
      seen.first = first_of_token;
      seen.last  = last_of_token;
      seen.empty = empty_token;
      seen.eot   = end_of_text;
      seen.line  = line_count;
      tracker.match_token(seen);
    end
  end

  // one text beat; returns on the falling edge after acceptance, push still high
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push      <= 1'b1;
    text_byte <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tracker.take_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // stop pushing and let every expected beat drain
  task automatic settle();
    push <= 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // both registers, back to back, only with the block drained
  task automatic apply_regs(input bit colons_v, input bit linec_v);
    settle();
    for (int r = 0; r < 2; r++) begin
      cfg_index <= (r == 0) ? CFG_IGNORE_COLONS : CFG_IGNORE_LINEC;
      cfg_data  <= (r == 0) ? colons_v : linec_v;
      cfg_valid <= 1'b1;
      @(posedge clk_i);
      while (!cfg_ready) @(posedge clk_i);
      tracker.set_reg((r == 0) ? CFG_IGNORE_COLONS : CFG_IGNORE_LINEC,
                      (r == 0) ? colons_v : linec_v);
      @(negedge clk_i);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(3))
      0:       return 8'h61 + 8'($urandom_range(25));
      1:       return 8'h30 + 8'($urandom_range(9));
      2:       return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(33, 255));
    endcase
  endfunction

  function automatic logic [7:0] any_char();
    return 8'($urandom_range(1, 255));
  endfunction

  // one piece of plausible source text; comment pieces do not count towards the total
  function automatic bit make_fragment();
    int unsigned kind;
    int unsigned n;
    logic [7:0]  b;
    bit          counted;
    counted = 1;
    text_buf.delete();
    kind = $urandom_range(11);
    case (kind)
      0, 1: begin
        n = $urandom_range(1, 6);
        repeat (n) text_buf.push_back(word_char());
      end
      2: text_buf.push_back(BREAK_CHARS[$urandom_range(12)]);
      3: text_buf.push_back($urandom_range(1) ? CH_LF : 8'($urandom_range(1, 32)));
      4, 5, 6: begin
        if (kind == 6) text_buf.push_back(CH_UPPERL);
        text_buf.push_back(CH_QUOTE);
        n = $urandom_range(0, 5);
        repeat (n) begin
          if ($urandom_range(4) == 0) begin
            text_buf.push_back(CH_BSLASH);
            text_buf.push_back(CH_QUOTE);
          end else begin
            b = any_char();
            text_buf.push_back((b == CH_QUOTE) ? 8'h71 : b);
          end
        end
        // now and then the string is left open
        if ($urandom_range(7) != 0) text_buf.push_back(CH_QUOTE);
      end
      7: begin
        text_buf.push_back(CH_UPPERL);
        case ($urandom_range(2))
          0:       text_buf.push_back(word_char());
          1:       text_buf.push_back(BREAK_CHARS[$urandom_range(12)]);
          default: text_buf.push_back(CH_SPACE);
        endcase
      end
      8: begin
        counted = 0;
        text_buf.push_back(CH_SLASH);
        text_buf.push_back(CH_SLASH);
        n = $urandom_range(0, 4);
        repeat (n) begin
          b = any_char();
          text_buf.push_back((b == CH_LF) ? 8'h63 : b);
        end
        text_buf.push_back(CH_LF);
      end
      9: begin
        counted = 0;
        text_buf.push_back(CH_SLASH);
        text_buf.push_back(CH_STAR);
        n = $urandom_range(0, 5);
        repeat (n) begin
          case ($urandom_range(3))
            0:       text_buf.push_back(CH_STAR);
            1:       text_buf.push_back(CH_SLASH);
            2:       text_buf.push_back(CH_LF);
            default: text_buf.push_back(any_char());
          endcase
        end
        text_buf.push_back(CH_STAR);
        text_buf.push_back(CH_SLASH);
      end
      10: begin
        text_buf.push_back(CH_SLASH);
        text_buf.push_back(any_char());
      end
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) text_buf.push_back(any_char());
      end
    endcase
    // end of text can land in any mode
    if ($urandom_range(15) == 0) text_buf.push_back(CH_NUL);
    if ($urandom_range(1)) text_buf.push_back(($urandom_range(3) == 0) ? CH_LF : CH_SPACE);
    return counted;
  endfunction

  task automatic random_text(input int unsigned n_bytes);
    int unsigned sent;
    bit          counted;
    sent = 0;
    while (sent < n_bytes) begin
      counted = make_fragment();
      if (counted) sent += text_buf.size();
      foreach (text_buf[i]) send_byte(text_buf[i]);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: high byte in a word, colon break, low whitespace
    send_text("a");
    send_byte(8'hff);
    send_text(":");
    send_byte(8'h01);
    // wide prefix with an escaped quote in the body, then an empty string
    send_text("L\"q\\\"\"");
    send_text("\"\"");
    // opener star does not close, line comment, slash before a word
    send_text("/*/*/");
    send_text("//\n");
    send_text("/x ");
    // end of text with an open string, a held slash and a held L
    send_text("\"z");
    send_byte(CH_NUL);
    send_text("/");
    send_byte(CH_NUL);
    send_text("L");
    send_byte(CH_NUL);

    // random phases over all four register settings
    for (int p = 0; p < 4; p++) begin
      apply_regs(p[0], p[1]);
      send_idle_pct = (p == 0) ? 19 : (p == 1) ? 50 : 0;
      recv_idle_pct = (p == 0) ? 50 : (p == 1) ? 19 : 0;
      if (p == 2) hold_reqs++;
      random_text(PHASE_BYTES);
    end
    send_byte(CH_NUL);
    settle();

    $display("Run covered %0d text beats and %0d token beats over four register settings,",
             bytes_sent, tracker.matched);
    $display("end of text in every mode, and a long pop stall that filled the block.");
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d beats never arrived", tracker.errors,
               tracker.pending.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[source_code_tokenizer.f]
+incdir+src
src/sct_pkg.sv
src/sct_class.sv
src/sct_scan.sv
src/sct_resq.sv
src/source_code_tokenizer.sv
tb/source_code_tokenizer_tb.sv
